// ===== hdl/sti_pkg.sv =====
// Shared types and constants for the sorted tagged list.
package sti_pkg;

    localparam int VALUE_W       = 32;
    localparam int TAG_W         = 8;
    localparam int CNT_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOCATE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
        logic [TAG_W-1:0]          tag;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [CNT_W-1:0]          count;
        logic                      head_valid;
        logic signed [VALUE_W-1:0] head_value;
        logic [TAG_W-1:0]          head_tag;
        logic [CNT_W-1:0]          position;
        logic                      found;
    } rsp_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [TAG_W-1:0]          tag;
    } slot_t;

    typedef struct packed {
        logic                      insert;
        logic                      remove;
        logic signed [VALUE_W-1:0] value;
        logic [TAG_W-1:0]          tag;
    } ctl_t;

    typedef struct packed {
        logic after;
        logic eq;
        logic hit;
    } flags_t;

endpackage

// ===== hdl/sorted_tagged_list.sv =====
// Top level of the sorted tagged list: a row of cells, the entry count and the result register.
// Sorted priority list of up to DEPTH signed value / tag entries held in a row of cells,
// smallest first, equal values in arrival order. For every command (insert, delete first
// match of a value, locate first entry with a tag) all cells compare the beat against
// their own entry at once and shift one place toward a neighbor, so a new beat is
// accepted every cycle while results are taken, and its result appears in the result
// register on the next cycle. While a result waits under stall the input stalls too.
// An insert into a full list is dropped with status full; a delete of an absent value
// reports status absent. Count and position are reported in five bits.
module sorted_tagged_list
#(
    parameter int DEPTH = sti_pkg::DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sti_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sti_pkg::rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    sti_pkg::rsp_t   rsp_reg;
    sti_pkg::rsp_t   rsp_next;

    logic            accept;
    logic            full;
    logic            exists;
    logic [CW-1:0]   position;
    sti_pkg::ctl_t   ctl;

    sti_pkg::slot_t  cell_slot [DEPTH];
    sti_pkg::slot_t  cell_next [DEPTH];
    sti_pkg::flags_t cell_flags [DEPTH];
    logic [DEPTH-1:0] occ;
    logic [DEPTH-1:0] after;
    logic [DEPTH-1:0] eq;
    logic [DEPTH-1:0] hit;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CW'(DEPTH));
    assign exists    = |eq;

    always_comb
    begin
        ctl.value  = req.value;
        ctl.tag    = req.tag;
        ctl.insert = accept && (req.command == sti_pkg::CMD_INSERT) && !full;
        ctl.remove = accept && (req.command == sti_pkg::CMD_DELETE) && exists;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sti_pkg::slot_t left_slot;
        sti_pkg::slot_t right_slot;
        logic           left_after;

        assign occ[i]   = (count_reg > CW'(i));
        assign after[i] = cell_flags[i].after;
        assign eq[i]    = cell_flags[i].eq;
        assign hit[i]   = cell_flags[i].hit;

        if (i == 0)
        begin : g_first
            assign left_slot  = cell_slot[i];
            assign left_after = 1'b0;
        end
        else
        begin : g_inner
            assign left_slot  = cell_slot[i-1];
            assign left_after = after[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_slot = cell_slot[i];
        end
        else
        begin : g_mid
            assign right_slot = cell_slot[i+1];
        end

        sti_cell u_cell
        (
            .clk        (clk),
            .occupied   (occ[i]),
            .ctl        (ctl),
            .left_slot  (left_slot),
            .left_after (left_after),
            .right_slot (right_slot),
            .slot       (cell_slot[i]),
            .slot_next  (cell_next[i]),
            .flags      (cell_flags[i])
        );
    end

    always_comb
    begin
        position = count_reg;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                position = CW'(i);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ctl.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - CW'(1);
        end

        rsp_next            = '0;
        rsp_next.count      = sti_pkg::CNT_W'(count_next);
        rsp_next.head_valid = (count_next != '0);
        if (count_next != '0)
        begin
            rsp_next.head_value = cell_next[0].value;
            rsp_next.head_tag   = cell_next[0].tag;
        end

        unique case (req.command)
            sti_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = sti_pkg::ST_FULL;
                end
            end
            sti_pkg::CMD_DELETE:
            begin
                if (!exists)
                begin
                    rsp_next.status = sti_pkg::ST_ABSENT;
                end
            end
            sti_pkg::CMD_LOCATE:
            begin
                rsp_next.position = sti_pkg::CNT_W'(position);
                rsp_next.found    = |hit;
            end
            default:
            begin
                rsp_next.status = sti_pkg::ST_DONE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/sti_cell.sv =====
// One list cell: holds an entry, compares it, and shifts toward its neighbors.
module sti_cell
(
    input  logic             clk,
    input  logic             occupied,
    input  sti_pkg::ctl_t    ctl,
    input  sti_pkg::slot_t   left_slot,
    input  logic             left_after,
    input  sti_pkg::slot_t   right_slot,
    output sti_pkg::slot_t   slot,
    output sti_pkg::slot_t   slot_next,
    output sti_pkg::flags_t  flags
);

    sti_pkg::slot_t slot_reg;
    logic           ge;

    always_comb
    begin
        flags.after = !occupied || ($signed(slot_reg.value) > $signed(ctl.value));
        flags.eq    = occupied && (slot_reg.value == ctl.value);
        flags.hit   = occupied && (slot_reg.tag == ctl.tag);
        ge          = occupied && ($signed(slot_reg.value) >= $signed(ctl.value));

        slot_next = slot_reg;
        priority if (ctl.insert && flags.after)
        begin
            if (left_after)
            begin
                slot_next = left_slot;
            end
            else
            begin
                slot_next.value = ctl.value;
                slot_next.tag   = ctl.tag;
            end
        end
        else if (ctl.remove && ge)
        begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ===== dv/tb_sorted_tagged_list.sv =====
// Self-checking testbench for the sorted tagged list: random and directed beats against a shadow list.
`timescale 1ns / 1ps

module tb_sorted_tagged_list;

    localparam int          DEPTH      = sti_pkg::DEPTH_DEFAULT;
    localparam logic [1:0]  CMD_NOP    = 2'd3;
    localparam int          RANDOM_N   = 1625;
    localparam int          QUIET_N    = 200;
    localparam int          LONG_HOLD  = 150;
    localparam int          STALL_MAX  = 3000;
    localparam int          DRAIN_WAIT = 8;

    class sorted_list_board;
        sti_pkg::slot_t slots[DEPTH];
        int unsigned    fill;
        sti_pkg::rsp_t  pending[$];
        int unsigned    mismatches;
        int unsigned    checked;
        int unsigned    n_insert, n_delete, n_locate, n_nop;
        int unsigned    n_full, n_absent, n_hit;

        function new();
            fill = 0;
            mismatches = 0;
            checked = 0;
            n_insert = 0;
            n_delete = 0;
            n_locate = 0;
            n_nop = 0;
            n_full = 0;
            n_absent = 0;
            n_hit = 0;
        endfunction

        function void note_request(sti_pkg::req_t r);
            sti_pkg::rsp_t x;
            int unsigned   p;
            int unsigned   i;
            x = '0;
            p = 0;
            case (r.command)
                sti_pkg::CMD_INSERT:
                begin
                    n_insert++;
                    if (fill >= DEPTH)
                    begin
                        x.status = sti_pkg::ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        while (p < fill && slots[p].value <= r.value)
                            p++;
                        for (i = fill; i > p; i--)
                            slots[i] = slots[i - 1];
                        slots[p].value = r.value;
                        slots[p].tag = r.tag;
                        fill++;
                    end
                end
                sti_pkg::CMD_DELETE:
                begin
                    n_delete++;
                    while (p < fill && slots[p].value != r.value)
                        p++;
                    if (p >= fill)
                    begin
                        x.status = sti_pkg::ST_ABSENT;
                        n_absent++;
                    end
                    else
                    begin
                        for (i = p; i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                end
                sti_pkg::CMD_LOCATE:
                begin
                    n_locate++;
                    while (p < fill && slots[p].tag != r.tag)
                        p++;
                    x.position = p[sti_pkg::CNT_W-1:0];
                    x.found = (p < fill);
                    if (p < fill)
                        n_hit++;
                end
                default:
                    n_nop++;
            endcase
            x.count = fill[sti_pkg::CNT_W-1:0];
            x.head_valid = (fill > 0);
            if (fill > 0)
            begin
                x.head_value = slots[0].value;
                x.head_tag = slots[0].tag;
            end
            pending.push_back(x);
        endfunction

        function void check_response(sti_pkg::rsp_t got);
            sti_pkg::rsp_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: status %0d count %0d",
                             $realtime, got.status, got.count);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.status !== exp.status || got.count !== exp.count
                || got.head_valid !== exp.head_valid || got.head_value !== exp.head_value
                || got.head_tag !== exp.head_tag || got.position !== exp.position
                || got.found !== exp.found)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result %0d mismatch", $realtime, checked);
                    $display("  expected status %0d count %0d head %0d/%0d/%0h pos %0d found %0d",
                             exp.status, exp.count, exp.head_valid, exp.head_value,
                             exp.head_tag, exp.position, exp.found);
                    $display("  actual   status %0d count %0d head %0d/%0d/%0h pos %0d found %0d",
                             got.status, got.count, got.head_valid, got.head_value,
                             got.head_tag, got.position, got.found);
                end
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    sti_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_stall;
    sti_pkg::rsp_t  rsp;

    sorted_list_board board;
    bit               idle_on;
    int unsigned      hold_requests;

    sorted_tagged_list #(.DEPTH(DEPTH)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    function automatic sti_pkg::req_t make_beat(logic [1:0] cmd,
                                                logic signed [sti_pkg::VALUE_W-1:0] value,
                                                logic [sti_pkg::TAG_W-1:0] tag);
        sti_pkg::req_t r;
        r.command = cmd;
        r.value = value;
        r.tag = tag;
        return r;
    endfunction

    function automatic logic signed [sti_pkg::VALUE_W-1:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                v = int'($urandom_range(0, 8)) - 4;
            5:
                case ($urandom_range(0, 3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 0;
                    default: v = -1;
                endcase
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [sti_pkg::TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 1) == 0)
            return sti_pkg::TAG_W'($urandom_range(0, 7));
        return sti_pkg::TAG_W'($urandom_range(0, 255));
    endfunction

    function automatic sti_pkg::req_t pick_beat(int unsigned grow_pct);
        sti_pkg::req_t r;
        int unsigned   roll;
        r = make_beat(sti_pkg::CMD_INSERT, pick_value(), pick_tag());
        roll = $urandom_range(0, 99);
        if (roll < 4)
            r.command = CMD_NOP;
        else if (roll >= 4 + grow_pct)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                r.command = sti_pkg::CMD_DELETE;
                if (board.fill > 0 && $urandom_range(0, 4) != 0)
                    r.value = board.slots[$urandom_range(0, board.fill - 1)].value;
            end
            else
            begin
                r.command = sti_pkg::CMD_LOCATE;
                if (board.fill > 0 && $urandom_range(0, 9) < 7)
                    r.tag = board.slots[$urandom_range(0, board.fill - 1)].tag;
            end
        end
        return r;
    endfunction

    task automatic send_beat(input sti_pkg::req_t item);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(item);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall bursts plus one long hold on request
    initial
    begin
        int unsigned stall_left;
        int unsigned holds_served;
        stall_left = 0;
        holds_served = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                board.check_response(rsp);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_MAX)
            begin
                $display("timeout: no beat moved for %0d cycles", quiet);
                $display("tb_sorted_tagged_list NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned grow;
        board = new();
        idle_on = 1'b1;
        hold_requests = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(make_beat(sti_pkg::CMD_LOCATE, 0, 8'hff));
        send_beat(make_beat(sti_pkg::CMD_DELETE, 0, 8'h00));
        send_beat(make_beat(sti_pkg::CMD_INSERT, 32'sh7fffffff, 8'hff));
        send_beat(make_beat(sti_pkg::CMD_INSERT, 32'sh80000000, 8'h00));
        send_beat(make_beat(sti_pkg::CMD_INSERT, 0, 8'h55));
        send_beat(make_beat(sti_pkg::CMD_INSERT, 0, 8'haa));
        send_beat(make_beat(sti_pkg::CMD_LOCATE, 32'sh12345678, 8'haa));
        send_beat(make_beat(sti_pkg::CMD_LOCATE, 0, 8'h77));
        send_beat(make_beat(sti_pkg::CMD_DELETE, 0, 8'h00));
        send_beat(make_beat(sti_pkg::CMD_DELETE, 32'sh00012345, 8'h00));
        send_beat(make_beat(CMD_NOP, -1, 8'hff));
        while (board.fill < DEPTH)
            send_beat(make_beat(sti_pkg::CMD_INSERT, pick_value(), pick_tag()));
        send_beat(make_beat(sti_pkg::CMD_INSERT, -1, 8'hff));

        for (i = 0; i < RANDOM_N; i++)
        begin
            grow = ((i / 80) % 2 == 0) ? 60 : 25;
            if (i == 400)
                hold_requests++;
            if (i == 900)
                wait_drained();
            if (i == RANDOM_N - QUIET_N)
                idle_on = 1'b0;
            send_beat(pick_beat(grow));
        end

        wait_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("covered %0d inserts (%0d dropped full), %0d deletes (%0d absent), "
                 , board.n_insert, board.n_full, board.n_delete, board.n_absent);
        $display("%0d locates (%0d hits), %0d no-ops; %0d results checked, %0d mismatches",
                 board.n_locate, board.n_hit, board.n_nop, board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_sorted_tagged_list OK");
        else
            $display("tb_sorted_tagged_list NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sti_pkg.sv
hdl/sti_cell.sv
hdl/sorted_tagged_list.sv
dv/tb_sorted_tagged_list.sv
